// File: sv/msui_pkg.sv
// ============================================================================
// msui_pkg: shared sizes, types and control bundles of the sort-unique block
// Holds the capacity, the derived widths and the command and status bundles
// that join the controller and the datapath.
// ============================================================================
`default_nettype none

package msui_pkg;

    // Capacity of the value store (2 to 64 entries).
    localparam int MAX_ITEMS = 64;

    // Address width of the stores, width of counts up to MAX_ITEMS, and the
    // width of run offsets that may reach twice the capacity.
    localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int SUM_W = CNT_W + 1;

    // Field widths of the stream payloads.
    localparam int VAL_W     = 64;
    localparam int POS_W     = 6;
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 72;
    localparam int M_PAD_W   = M_TDATA_W - POS_W - VAL_W;

    typedef logic        [IDX_W-1:0] idx_t;
    typedef logic        [CNT_W-1:0] cnt_t;
    typedef logic        [SUM_W-1:0] sum_t;
    typedef logic signed [VAL_W-1:0] val_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // a request is accepted on the input side
        logic init_clr;   // start a new sort: clear offsets and pass width
        logic init_wr;    // write the identity order and unit run lengths
        logic pair_clr;   // clear merge counters and read the left run length
        logic rl_rd_hi;   // read the run length of the right run
        logic len1_ld;    // capture the left run length
        logic len2_ld;    // capture the right run length
        logic side;       // 0: left run, 1: right run
        logic head_ld;    // load a run head from the order and value stores
        logic pick;       // choose the smaller head
        logic wr;         // write the chosen entry unless it repeats a value
        logic run_done;   // store the merged run length, move to the next pair
        logic pass_end;   // swap order stores and double the run width
        logic out_ld;     // load the result register
        logic out_take;   // a result request is taken on the output side
        logic set_done;   // clear the load count and the drop flag
    } msui_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic init_last;
        logic size_ge_n;
        logic a_more;
        logic b_more;
        logic len2_zero;
        logic refill;
        logic next_i_lt_n;
        logic dbl_lt_n;
        logic pick_side;
        logic out_last;
    } msui_sts_t;

endpackage

`default_nettype wire

// File: sv/msui_dpath.sv
// ============================================================================
// msui_dpath: stores, counters and compare logic of the sort-unique block
// Holds the value store, the two order stores and the run length store, and
// carries out one merge step at a time as the controller commands.
// ============================================================================
`default_nettype none

module msui_dpath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire msui_pkg::msui_cmd_t           cmd,
    output msui_pkg::msui_sts_t                sts,
    input  wire logic [msui_pkg::VAL_W-1:0]    in_value,
    output logic      [msui_pkg::POS_W-1:0]    out_position,
    output logic      [msui_pkg::VAL_W-1:0]    out_value,
    output logic                               out_last,
    output logic                               out_dropped
);
    import msui_pkg::*;

    // Stores
    val_t value_mem   [MAX_ITEMS];
    idx_t order_a_mem [MAX_ITEMS];
    idx_t order_b_mem [MAX_ITEMS];
    cnt_t rl_mem      [MAX_ITEMS];

    // Control registers
    cnt_t count_reg;
    logic ovf_reg;
    logic src_sel_reg;

    // Counters and run bookkeeping
    sum_t size_reg;
    sum_t i_reg;
    cnt_t a_reg;
    cnt_t b_reg;
    cnt_t j_reg;
    cnt_t len1_reg;
    cnt_t len2_reg;

    // Run heads, chosen entry and last kept value
    idx_t head_a_pos_reg;
    idx_t head_b_pos_reg;
    val_t head_a_val_reg;
    val_t head_b_val_reg;
    idx_t pick_pos_reg;
    val_t pick_val_reg;
    logic pick_side_reg;
    val_t last_val_reg;

    // Memory read registers
    idx_t ord_a_q_reg;
    idx_t ord_b_q_reg;
    cnt_t rl_q_reg;

    // Result register
    idx_t out_pos_reg;
    val_t out_val_reg;
    logic out_last_reg;
    logic out_drop_reg;

    // Combinational helpers
    sum_t i2;
    sum_t i_step;
    sum_t size_dbl;
    sum_t count_ext;
    idx_t order_q;
    idx_t ord_rd_addr;
    idx_t ord_wr_addr;
    idx_t ord_wr_data;
    idx_t rl_rd_addr;
    idx_t rl_wr_addr;
    cnt_t rl_wr_data;
    logic has_room;
    logic keep;
    logic pick_b;

    // Offsets and addresses
    always_comb begin
        count_ext   = SUM_W'(count_reg);
        i2          = i_reg + size_reg;
        size_dbl    = size_reg << 1;
        i_step      = i_reg + size_dbl;
        order_q     = src_sel_reg ? ord_b_q_reg : ord_a_q_reg;
        has_room    = (count_reg < CNT_W'(MAX_ITEMS));
        ord_rd_addr = cmd.side ? IDX_W'(i2 + SUM_W'(b_reg))
                               : IDX_W'(i_reg + SUM_W'(a_reg));
        ord_wr_addr = cmd.init_wr ? a_reg[IDX_W-1:0] : IDX_W'(i_reg + SUM_W'(j_reg));
        ord_wr_data = cmd.init_wr ? a_reg[IDX_W-1:0] : pick_pos_reg;
        rl_rd_addr  = cmd.rl_rd_hi ? i2[IDX_W-1:0] : i_reg[IDX_W-1:0];
        rl_wr_addr  = cmd.init_wr ? a_reg[IDX_W-1:0] : i_reg[IDX_W-1:0];
        rl_wr_data  = cmd.init_wr ? CNT_W'(1) : j_reg;
    end

    // Merge decisions: the left head wins ties, a repeat of the last kept value is dropped
    always_comb begin
        pick_b = !((a_reg < len1_reg) &&
                   (!(b_reg < len2_reg) || !(head_b_val_reg < head_a_val_reg)));
        keep   = cmd.wr && ((j_reg == '0) || (last_val_reg < pick_val_reg));
    end

    // Value store
    always_ff @(posedge aclk) begin
        if (cmd.load && has_room) begin
            value_mem[count_reg[IDX_W-1:0]] <= val_t'(in_value);
        end
        if (cmd.head_ld && !cmd.side) begin
            head_a_val_reg <= value_mem[order_q];
        end
        if (cmd.head_ld && cmd.side) begin
            head_b_val_reg <= value_mem[order_q];
        end
        if (cmd.out_ld) begin
            out_val_reg <= value_mem[order_q];
        end
    end

    // Order stores: the source is read, the destination is written
    always_ff @(posedge aclk) begin
        if (cmd.init_wr || (keep && src_sel_reg)) begin
            order_a_mem[ord_wr_addr] <= ord_wr_data;
        end
        ord_a_q_reg <= order_a_mem[ord_rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (keep && !src_sel_reg) begin
            order_b_mem[ord_wr_addr] <= ord_wr_data;
        end
        ord_b_q_reg <= order_b_mem[ord_rd_addr];
    end

    // Run length store
    always_ff @(posedge aclk) begin
        if (cmd.init_wr || cmd.run_done) begin
            rl_mem[rl_wr_addr] <= rl_wr_data;
        end
        rl_q_reg <= rl_mem[rl_rd_addr];
    end

    // Load count, drop flag and order store selection
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            src_sel_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                if (has_room) begin
                    count_reg <= count_reg + CNT_W'(1);
                end else begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.init_clr) begin
                src_sel_reg <= 1'b0;
            end
            if (cmd.pass_end) begin
                src_sel_reg <= !src_sel_reg;
            end
            if (cmd.set_done) begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
        end
    end

    // Pass, pair and merge counters
    always_ff @(posedge aclk) begin
        if (cmd.init_clr) begin
            a_reg    <= '0;
            i_reg    <= '0;
            size_reg <= SUM_W'(1);
        end
        if (cmd.init_wr || cmd.out_take) begin
            a_reg <= a_reg + CNT_W'(1);
        end
        if (cmd.pair_clr) begin
            a_reg <= '0;
            b_reg <= '0;
            j_reg <= '0;
        end
        if (cmd.len1_ld) begin
            len1_reg <= rl_q_reg;
        end
        if (cmd.len2_ld) begin
            len2_reg <= (i2 < count_ext) ? rl_q_reg : '0;
        end
        if (cmd.wr) begin
            if (pick_side_reg) begin
                b_reg <= b_reg + CNT_W'(1);
            end else begin
                a_reg <= a_reg + CNT_W'(1);
            end
        end
        if (keep) begin
            j_reg        <= j_reg + CNT_W'(1);
            last_val_reg <= pick_val_reg;
        end
        if (cmd.run_done) begin
            i_reg <= cmd.pass_end ? '0 : i_step;
        end
        if (cmd.pass_end) begin
            size_reg <= size_dbl;
        end
    end

    // Run heads and the chosen entry
    always_ff @(posedge aclk) begin
        if (cmd.head_ld && !cmd.side) begin
            head_a_pos_reg <= order_q;
        end
        if (cmd.head_ld && cmd.side) begin
            head_b_pos_reg <= order_q;
        end
        if (cmd.pick) begin
            pick_side_reg <= pick_b;
            pick_pos_reg  <= pick_b ? head_b_pos_reg : head_a_pos_reg;
            pick_val_reg  <= pick_b ? head_b_val_reg : head_a_val_reg;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.out_ld) begin
            out_pos_reg  <= order_q;
            out_last_reg <= ((SUM_W'(a_reg) + SUM_W'(1)) == SUM_W'(len1_reg));
            out_drop_reg <= ovf_reg;
        end
    end

    // Status toward the controller
    always_comb begin
        sts.init_last   = ((SUM_W'(a_reg) + SUM_W'(1)) == count_ext);
        sts.size_ge_n   = (size_reg >= count_ext);
        sts.a_more      = (a_reg < len1_reg);
        sts.b_more      = (b_reg < len2_reg);
        sts.len2_zero   = (len2_reg == '0);
        sts.refill      = pick_side_reg ? ((SUM_W'(b_reg) + SUM_W'(1)) < SUM_W'(len2_reg))
                                        : ((SUM_W'(a_reg) + SUM_W'(1)) < SUM_W'(len1_reg));
        sts.next_i_lt_n = (i_step < count_ext);
        sts.dbl_lt_n    = (size_dbl < count_ext);
        sts.pick_side   = pick_side_reg;
        sts.out_last    = out_last_reg;
    end

    assign out_position = POS_W'(out_pos_reg);
    assign out_value    = out_val_reg;
    assign out_last     = out_last_reg;
    assign out_dropped  = out_drop_reg;

endmodule

`default_nettype wire

// File: sv/msui_ctrl.sv
// ============================================================================
// msui_ctrl: sequencer of the sort-unique block
// Steps through loading, order setup, the merge passes and the result
// readout, and drives the stream handshakes.
// ============================================================================
`default_nettype none

module msui_ctrl (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_tvalid,
    input  wire logic                    s_tlast,
    output logic                         s_tready,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    input  wire msui_pkg::msui_sts_t     sts,
    output msui_pkg::msui_cmd_t          cmd
);
    import msui_pkg::*;

    typedef enum logic [13:0] {
        ST_LOAD  = 14'b00000000000001,
        ST_INIT  = 14'b00000000000010,
        ST_PAIR  = 14'b00000000000100,
        ST_PAIR2 = 14'b00000000001000,
        ST_PAIR3 = 14'b00000000010000,
        ST_F1    = 14'b00000000100000,
        ST_F2    = 14'b00000001000000,
        ST_CMP   = 14'b00000010000000,
        ST_WR    = 14'b00000100000000,
        ST_OUT0  = 14'b00001000000000,
        ST_OUT1  = 14'b00010000000000,
        ST_O1    = 14'b00100000000000,
        ST_O2    = 14'b01000000000000,
        ST_O3    = 14'b10000000000000
    } msui_state_t;

    msui_state_t state_reg;
    msui_state_t state_next;
    logic        side_reg;
    logic        side_next;
    logic        prime_reg;
    logic        prime_next;

    // State and fetch bookkeeping registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            side_reg  <= 1'b0;
            prime_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            side_reg  <= side_next;
            prime_reg <= prime_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        side_next  = side_reg;
        prime_next = prime_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    if (s_tlast) begin
                        cmd.init_clr = 1'b1;
                        state_next   = ST_INIT;
                    end
                end
            end
            ST_INIT: begin
                cmd.init_wr = 1'b1;
                if (sts.init_last) begin
                    state_next = sts.size_ge_n ? ST_OUT0 : ST_PAIR;
                end
            end
            ST_PAIR: begin
                cmd.pair_clr = 1'b1;
                state_next   = ST_PAIR2;
            end
            ST_PAIR2: begin
                cmd.len1_ld  = 1'b1;
                cmd.rl_rd_hi = 1'b1;
                state_next   = ST_PAIR3;
            end
            ST_PAIR3: begin
                cmd.len2_ld = 1'b1;
                side_next   = 1'b0;
                prime_next  = 1'b1;
                state_next  = ST_F1;
            end
            ST_F1: begin
                cmd.side   = side_reg;
                state_next = ST_F2;
            end
            ST_F2: begin
                cmd.side    = side_reg;
                cmd.head_ld = 1'b1;
                // After the left head of a fresh pair, fetch the right head too unless the right run is empty.
                if (prime_reg && !side_reg && !sts.len2_zero) begin
                    side_next  = 1'b1;
                    state_next = ST_F1;
                end else begin
                    prime_next = 1'b0;
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                if (!sts.a_more && !sts.b_more) begin
                    cmd.run_done = 1'b1;
                    if (sts.next_i_lt_n) begin
                        state_next = ST_PAIR;
                    end else begin
                        cmd.pass_end = 1'b1;
                        state_next   = sts.dbl_lt_n ? ST_PAIR : ST_OUT0;
                    end
                end else begin
                    cmd.pick   = 1'b1;
                    state_next = ST_WR;
                end
            end
            ST_WR: begin
                cmd.wr = 1'b1;
                if (sts.refill) begin
                    side_next  = sts.pick_side;
                    state_next = ST_F1;
                end else begin
                    state_next = ST_CMP;
                end
            end
            ST_OUT0: begin
                cmd.pair_clr = 1'b1;
                state_next   = ST_OUT1;
            end
            ST_OUT1: begin
                cmd.len1_ld = 1'b1;
                state_next  = ST_O1;
            end
            ST_O1: begin
                state_next = ST_O2;
            end
            ST_O2: begin
                cmd.out_ld = 1'b1;
                state_next = ST_O3;
            end
            ST_O3: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    cmd.out_take = 1'b1;
                    if (sts.out_last) begin
                        cmd.set_done = 1'b1;
                        state_next   = ST_LOAD;
                    end else begin
                        state_next = ST_O1;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: sv/merge_sort_unique_indices.sv
// ============================================================================
// merge_sort_unique_indices: sorted unique positions of a loaded value set
// Loads signed values, sorts their positions with bottom-up merge passes
// that drop repeated values, and streams out one result per distinct value.
// ============================================================================
// Each input request carries one signed 64-bit value; tlast closes the set.
// Loading takes one request per cycle. Values past the 64-entry capacity are
// dropped, and every result of that set then shows the drop flag in tuser.
// After the last request the block writes the identity order and unit run
// lengths and runs ceil(log2(n)) merge passes for n loaded values; each merge
// step compares the run heads and writes the chosen entry, reading the order
// store and then the value store when a run needs a new head, and each pair
// of runs also fetches its run lengths and closes the merged run. Repeated
// values make the passes shorter. Each result is read from the order and
// value stores into the result register and then offered, and the next is
// not fetched until it is taken. Results leave ascending by value, each
// with the earliest load position of that value; tlast marks the final
// result. No input is taken while a set is being sorted or read out.
`default_nettype none

module merge_sort_unique_indices (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [msui_pkg::S_TDATA_W-1:0]    s_tdata,   // [63:0] value
    input  wire logic                              s_tlast,   // final_req
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [msui_pkg::M_TDATA_W-1:0]    m_tdata,   // [5:0] position,
                                                              // [69:6] unique_value
    output logic                                   m_tlast,   // end_of_run
    output logic                                   m_tuser    // [0] dropped
);
    import msui_pkg::*;

    msui_cmd_t              cmd;
    msui_sts_t              sts;
    logic [POS_W-1:0]       out_position;
    logic [VAL_W-1:0]       out_value;

    // Sequencer
    msui_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Stores and merge logic
    msui_dpath u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .in_value     (s_tdata[VAL_W-1:0]),
        .out_position (out_position),
        .out_value    (out_value),
        .out_last     (m_tlast),
        .out_dropped  (m_tuser)
    );

    // Result packing
    assign m_tdata = {{M_PAD_W{1'b0}}, out_value, out_position};

    // The block never takes input while a result is offered.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is offered");

    // Closing a set stops input until the results are out.
    a_stop_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input still ready after the last request of a set");

    // Once the last result is taken, the next set may start at once.
    a_resume_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
        else $error("block did not return to loading after the last result");

endmodule

`default_nettype wire
